// File: rtl/gww_pkg.sv
// Shared constants and helpers for the greedy word wrap core.
package gww_pkg;

    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

    // Whitespace: tab through carriage return, or space.
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

endpackage

// File: rtl/greedy_word_wrap_core.sv
// Greedy word wrap core: top level with state machine and output register.
//
// Input stream (s_axis): one text byte per transaction in tdata; tlast marks
// end of text, which flushes the pending word, sends a final newline and
// returns the text state to reset (the width error flag stays sticky).
// Output stream (m_axis): one output byte per transaction in tdata, tlast on
// the final byte caused by an input transaction, tuser = width error flag.
// Config: cfg_we writes cfg_wdata into line_width (reset 80). The user must
// write only while idle; the block itself does not enforce it.
// Non-blank bytes are written into the word RAM while it has room, and input
// stays ready for the next byte. A blank or end of text that places a word
// is accepted, then output follows one byte per cycle while the receiver does
// not stall: the break/space byte if any, the word bytes read from the RAM
// (registered read, pipelined so one byte per cycle), then up to two newlines.
// The first byte passes through the state register, then the output register,
// after acceptance (the first RAM read is issued at acceptance). Input stays
// not ready until the last byte of the item is in the output register.
// Reset clears all control state at once; the RAM needs no clearing.
// A stalled receiver holds the output register and freezes the sequencer.
module greedy_word_wrap_core #(
    parameter int MAX_WORD = 60
) (
    input  logic       clk,
    input  logic       rst_n,
    // line_width
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    // tdata: in_char[7:0]; tlast: end_of_text
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    // tdata: out_char[7:0]; tlast: last_of_run; tuser: width_exceeded
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    output logic       m_axis_tuser
);

    localparam int AW = $clog2(MAX_WORD);
    localparam int LW = $clog2(MAX_WORD + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_WORD,
        ST_TAIL
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    lw_reg, lw_next;        // line width
    logic [LW-1:0] wl_reg, wl_next;        // characters buffered
    logic [7:0]    col_reg, col_next;      // line column
    logic          nl_reg, nl_next;        // newline seen
    logic          pd_reg, pd_next;        // paragraph done
    logic          err_reg, err_next;      // sticky error
    logic [LW-1:0] n_reg, n_next;          // length of word being sent
    logic [LW-1:0] idx_reg, idx_next;      // reads issued
    logic          rdv_reg, rdv_next;      // RAM read data holds a pending char
    logic [7:0]    prefix_reg, prefix_next;
    logic [1:0]    tail_reg, tail_next;    // trailing newlines left
    logic          ovalid_reg, ovalid_next;
    logic [7:0]    ochar_reg, ochar_next;
    logic          olast_reg, olast_next;
    logic          oerr_reg, oerr_next;

    // accept-time decode
    logic       accept;
    logic       blank;
    logic       place;
    logic       brk;
    logic       spc;
    logic [8:0] col9;
    logic [8:0] n9;
    logic [8:0] col_after;
    logic       para;
    logic       room;

    logic          load_ok;
    logic          consume;
    logic          last_char;
    logic          issue;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign blank   = gww_pkg::is_blank(s_axis_tdata);
    assign place   = (s_axis_tlast || blank) && (wl_reg != '0);
    assign col9    = {1'b0, col_reg};
    assign n9      = 9'(wl_reg);
    assign brk     = place && (col_reg != 8'd0) && ((col9 + 9'd1 + n9) > {1'b0, lw_reg});
    assign spc     = place && (col_reg != 8'd0) && !brk;
    assign col_after = (spc ? (col9 + 9'd1) : 9'd0) + n9;
    assign para    = !s_axis_tlast && (s_axis_tdata == gww_pkg::CHAR_NEWLINE) && nl_reg && !pd_reg;
    assign room    = (wl_reg < LW'(MAX_WORD));

    assign load_ok   = !ovalid_reg || m_axis_tready;
    assign consume   = (state_reg == ST_WORD) && rdv_reg && load_ok;
    assign last_char = (idx_reg == n_reg);
    assign issue     = (state_reg == ST_WORD) && !last_char && (!rdv_reg || consume);

    assign ram_we    = accept && !s_axis_tlast && !blank && room;
    assign ram_re    = (accept && place) || issue;
    assign ram_raddr = (state_reg == ST_WORD) ? idx_reg[AW-1:0] : '0;

    gww_word_ram #(
        .DEPTH (MAX_WORD),
        .AW    (AW)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wl_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        lw_next     = cfg_we ? cfg_wdata : lw_reg;
        wl_next     = wl_reg;
        col_next    = col_reg;
        nl_next     = nl_reg;
        pd_next     = pd_reg;
        err_next    = err_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        rdv_next    = rdv_reg;
        prefix_next = prefix_reg;
        tail_next   = tail_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_axis_tlast && !blank)
                    begin
                        // word character
                        if (room)
                        begin
                            wl_next = wl_reg + LW'(1);
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                        nl_next = 1'b0;
                        pd_next = 1'b0;
                    end
                    else
                    begin
                        n_next      = wl_reg;
                        wl_next     = '0;
                        prefix_next = brk ? gww_pkg::CHAR_NEWLINE : gww_pkg::CHAR_SPACE;
                        idx_next    = place ? LW'(1) : '0;
                        rdv_next    = place;
                        if (place)
                        begin
                            col_next = col_after[7:0];
                            if (col_after > {1'b0, lw_reg})
                            begin
                                err_next = 1'b1;
                            end
                        end
                        if (s_axis_tlast)
                        begin
                            tail_next = 2'd1;
                            col_next  = 8'd0;
                            nl_next   = 1'b0;
                            pd_next   = 1'b0;
                        end
                        else if (s_axis_tdata == gww_pkg::CHAR_NEWLINE)
                        begin
                            tail_next = para ? 2'd2 : 2'd0;
                            if (!nl_reg)
                            begin
                                nl_next = 1'b1;
                            end
                            else if (!pd_reg)
                            begin
                                col_next = 8'd0;
                                nl_next  = 1'b0;
                                pd_next  = 1'b1;
                            end
                        end
                        else
                        begin
                            tail_next = 2'd0;
                        end

                        if (brk || spc)
                        begin
                            state_next = ST_PREFIX;
                        end
                        else if (place)
                        begin
                            state_next = ST_WORD;
                        end
                        else if (s_axis_tlast || para)
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                end
            end

            ST_PREFIX:
            begin
                if (load_ok)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = prefix_reg;
                    olast_next  = 1'b0;
                    oerr_next   = err_reg;
                    state_next  = ST_WORD;
                end
            end

            ST_WORD:
            begin
                if (consume)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = ram_rdata;
                    olast_next  = last_char && (tail_reg == 2'd0);
                    oerr_next   = err_reg;
                    if (last_char)
                    begin
                        state_next = (tail_reg != 2'd0) ? ST_TAIL : ST_IDLE;
                    end
                end
                if (issue)
                begin
                    idx_next = idx_reg + LW'(1);
                    rdv_next = 1'b1;
                end
                else if (consume)
                begin
                    rdv_next = 1'b0;
                end
            end

            ST_TAIL:
            begin
                if (load_ok)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = gww_pkg::CHAR_NEWLINE;
                    olast_next  = (tail_reg == 2'd1);
                    oerr_next   = err_reg;
                    tail_next   = tail_reg - 2'd1;
                    if (tail_reg == 2'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lw_reg     <= gww_pkg::LINE_WIDTH_RESET;
            wl_reg     <= '0;
            col_reg    <= 8'd0;
            nl_reg     <= 1'b0;
            pd_reg     <= 1'b0;
            err_reg    <= 1'b0;
            idx_reg    <= '0;
            rdv_reg    <= 1'b0;
            tail_reg   <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lw_reg     <= lw_next;
            wl_reg     <= wl_next;
            col_reg    <= col_next;
            nl_reg     <= nl_next;
            pd_reg     <= pd_next;
            err_reg    <= err_next;
            idx_reg    <= idx_next;
            rdv_reg    <= rdv_next;
            tail_reg   <= tail_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        prefix_reg <= prefix_next;
        ochar_reg  <= ochar_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = oerr_reg;

endmodule

// File: rtl/gww_word_ram.sv
// Word character store: one write port, one registered read port.
module gww_word_ram #(
    parameter int DEPTH = 60,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gww_checker.sv
// Port-level checks for the greedy word wrap core, bound to the top level.
module gww_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // error flag never drops once reported
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |=> !m_axis_tvalid || m_axis_tuser)
        else $error("width error flag cleared");

    // only newline and space appear as whitespace; a run never ends in space
    a_out_chars: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata != gww_pkg::CHAR_TAB && m_axis_tdata != 8'd11
            && m_axis_tdata != 8'd12 && m_axis_tdata != gww_pkg::CHAR_CR
            && !(m_axis_tlast && m_axis_tdata == gww_pkg::CHAR_SPACE))
        else $error("unexpected output byte");

    // end of text always produces output, so input must stall after it
    a_eot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after end of text");

endmodule

bind greedy_word_wrap_core gww_checker u_gww_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_greedy_word_wrap_core.sv
// Self-checking testbench for the greedy word wrap core: stream stimulus, wrap predictor.
module tb_greedy_word_wrap_core;

    localparam int MAX_WORD    = 60;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block
    localparam int SETTLE      = 8;     // cycles after the last byte before a config write
    localparam int N_ROWS      = 24;

    localparam logic [7:0] NL = gww_pkg::CHAR_NEWLINE;
    localparam logic [7:0] SP = gww_pkg::CHAR_SPACE;

    // One output transaction: out_char, last_of_run, width_exceeded.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } wrap_byte_t;

    // Directed row. When typed is set, n_out bytes (b0, then b1) are the
    // expected output and the predictor output for that row is only used to
    // advance its state.
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        logic [1:0] n_out;
        logic [7:0] b0;
        logic [7:0] b1;
    } stim_row_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_we        = 1'b0;
    logic [7:0] cfg_wdata     = 8'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       m_axis_tuser;

    // Predictor state
    logic [7:0] word_buf [MAX_WORD];
    int         word_len;
    int         column;
    bit         after_newline;
    bit         para_closed;
    bit         overrun;
    logic [7:0] width_reg;

    wrap_byte_t step_bytes[$];      // bytes caused by the item just accepted
    wrap_byte_t pending_bytes[$];   // bytes still owed by the core, oldest first

    int errors        = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int widths_used   = 0;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;
    bit hold_request  = 1'b0;

    // Directed part. Error flag is still clear throughout, so typed rows expect 0.
    stim_row_t stim_table [N_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 2'd1, NL, 8'h00},     // end of text, nothing pending
        '{8'h41, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{8'hFF, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // top byte is a word char
        '{8'h00, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // zero byte is a word char
        '{8'd9,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},  // tab places the word
        '{NL,    1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // first newline: silent
        '{NL,    1'b0, 1'b1, 2'd2, NL, NL},        // second newline ends paragraph
        '{NL,    1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // third in a row: ignored
        '{gww_pkg::CHAR_CR, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{8'd11, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{8'd12, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{SP,    1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{8'd8,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // just below the blank range
        '{8'd14, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // just above it
        '{8'd31, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{8'd33, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{8'h7F, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{SP,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},  // word on an empty line
        '{8'h80, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{NL,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},  // space then word, newline noted
        '{8'h5A, 1'b1, 1'b1, 2'd1, NL, 8'h00},     // end of text ignores tdata
        '{SP,    1'b1, 1'b1, 2'd1, NL, 8'h00},
        '{NL,    1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // state was cleared by end of text
        '{NL,    1'b0, 1'b1, 2'd2, NL, NL}
    };

    greedy_word_wrap_core #(
        .MAX_WORD (MAX_WORD)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // in_char[7:0]
        .s_axis_tlast  (s_axis_tlast),     // end_of_text
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // out_char[7:0]
        .m_axis_tlast  (m_axis_tlast),     // last_of_run
        .m_axis_tuser  (m_axis_tuser)      // width_exceeded
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Wrap predictor
    // ------------------------------------------------------------------

    function automatic bit blank_char(input logic [7:0] c);
        case (c)
            8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32: blank_char = 1'b1;
            default:                                 blank_char = 1'b0;
        endcase
    endfunction

    function automatic void emit_byte(input logic [7:0] c);
        wrap_byte_t b;
        b.ch   = c;
        b.last = 1'b0;
        b.err  = 1'b0;
        step_bytes.push_back(b);
    endfunction

    // Put the buffered word on the line: newline if it would not fit on a
    // non-empty line, else a space unless the line is empty.
    function automatic void place_pending_word();
        int n;
        int c;
        int i;
        n = word_len;
        c = column;
        if (n == 0)
            return;
        if (c != 0 && c + 1 + n > int'(width_reg))
        begin
            emit_byte(NL);
            c = 0;
        end
        if (c != 0)
        begin
            emit_byte(SP);
            c++;
        end
        for (i = 0; i < n; i++)
            emit_byte(word_buf[i]);
        c += n;
        if (c > int'(width_reg))
            overrun = 1'b1;
        column   = c & 255;
        word_len = 0;
    endfunction

    // Advance the predictor by one accepted input transaction.
    function automatic void wrap_step(input logic [7:0] c, input logic eot);
        wrap_byte_t b;
        int k;
        step_bytes.delete();
        if (eot)
        begin
            place_pending_word();
            emit_byte(NL);
            word_len      = 0;
            column        = 0;
            after_newline = 1'b0;
            para_closed   = 1'b0;
        end
        else if (blank_char(c))
        begin
            place_pending_word();
            if (c == NL)
            begin
                if (!after_newline)
                    after_newline = 1'b1;
                else if (!para_closed)
                begin
                    emit_byte(NL);
                    emit_byte(NL);
                    column        = 0;
                    after_newline = 1'b0;
                    para_closed   = 1'b1;
                end
            end
        end
        else
        begin
            // characters past the buffer are dropped and flag the error
            if (word_len < MAX_WORD)
            begin
                word_buf[word_len] = c;
                word_len++;
            end
            else
                overrun = 1'b1;
            after_newline = 1'b0;
            para_closed   = 1'b0;
        end
        // tlast on the final byte; tuser is the flag as it stands after the item
        for (k = 0; k < step_bytes.size(); k++)
        begin
            b      = step_bytes[k];
            b.last = (k == step_bytes.size() - 1);
            b.err  = overrun;
            step_bytes[k] = b;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int pick_gap(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0)
            pick_gap = 0;
        else
            pick_gap = $urandom_range(0, 11);
    endfunction

    // Offer one transaction and wait for it to be taken.
    task automatic offer(input logic [7:0] c, input logic eot);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Offer, predict, and queue the predicted bytes.
    task automatic feed(input logic [7:0] c, input logic eot);
        offer(c, eot);
        wrap_step(c, eot);
        while (step_bytes.size() != 0)
            pending_bytes.push_back(step_bytes.pop_front());
    endtask

    // Sender goes quiet until every owed byte has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    task automatic set_width(input logic [7:0] w);
        drain();
        // word bytes give no output but may still be in flight
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg = w;
        widths_used++;
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            c = 8'h61 + 8'($urandom_range(0, 25));
        else
        begin
            c = 8'($urandom_range(0, 255));
            while (blank_char(c))
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Mostly words and separators with random content; some raw noise and
    // stray end-of-text. pause_at > 0 drains the core once mid-phase.
    task automatic run_random(input int n_items, input bit force_long, input int pause_at);
        int start;
        int r;
        int len;
        int k;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if (pause_at > 0 && items_sent - start >= pause_at)
            begin
                drain();
                pause_at = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                feed(8'($urandom_range(0, 255)), 1'b0);
            else if (r < 12)
                feed(8'($urandom_range(0, 255)), 1'b1);
            else
            begin
                r = $urandom_range(0, 99);
                if (force_long)
                begin
                    len        = MAX_WORD + 2;   // overflows the word buffer
                    force_long = 1'b0;
                end
                else if (r < 80)
                    len = $urandom_range(1, 8);
                else if (r < 94)
                    len = $urandom_range(9, 30);
                else
                    len = $urandom_range(MAX_WORD - 5, MAX_WORD + 10);
                for (k = 0; k < len; k++)
                    feed(word_char(), 1'b0);
                r = $urandom_range(0, 99);
                if (r < 60)
                    feed(SP, 1'b0);
                else if (r < 72)
                begin
                    k = $urandom_range(0, 3);
                    feed((k == 0) ? gww_pkg::CHAR_TAB : 8'(10 + k), 1'b0);
                end
                else
                begin
                    // one, two or three newlines in a row
                    k = (r < 87) ? 1 : (r < 95) ? 2 : 3;
                    repeat (k) feed(NL, 1'b0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, quiet stretches, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = pick_gap(rx_quiet);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Output checker: every accepted byte against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : out_check
        wrap_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_checked++;
            if (pending_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output byte: expected none, actual %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want.ch)
                begin
                    errors++;
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, want.ch, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: last_of_run mismatch: expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                end
                if (m_axis_tuser !== want.err)
                begin
                    errors++;
                    $display("%0t: width_exceeded mismatch: expected %b, actual %b",
                             $time, want.err, m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int i;
        int k;
        word_len      = 0;
        column        = 0;
        after_newline = 1'b0;
        para_closed   = 1'b0;
        overrun       = 1'b0;
        width_reg     = gww_pkg::LINE_WIDTH_RESET;
        for (i = 0; i < MAX_WORD; i++)
            word_buf[i] = 8'h00;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset width
        for (i = 0; i < N_ROWS; i++)
        begin
            if (stim_table[i].typed)
            begin
                offer(stim_table[i].ch, stim_table[i].eot);
                wrap_step(stim_table[i].ch, stim_table[i].eot);
                for (k = 0; k < int'(stim_table[i].n_out); k++)
                    pending_bytes.push_back('{(k == 0) ? stim_table[i].b0 : stim_table[i].b1,
                                              k == int'(stim_table[i].n_out) - 1, 1'b0});
            end
            else
                feed(stim_table[i].ch, stim_table[i].eot);
        end

        // Reset width, starting with a word that overruns the buffer
        run_random(5, 1'b1, 0);

        // Widest lines; receiver holds off while the sender keeps pushing
        set_width(8'd255);
        hold_request = 1'b1;
        tx_quiet     = 1'b1;
        run_random(18, 1'b0, 0);
        tx_quiet     = 1'b0;

        // Narrowest legal width, both sides back to back
        set_width(8'd1);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_random(12, 1'b0, 0);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Zero width: every placed word flags the error
        set_width(8'd0);
        run_random(8, 1'b0, 0);

        // Mid width, with a full drain partway through
        set_width(8'($urandom_range(8, 40)));
        run_random(16, 1'b0, 8);

        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d input bytes at %0d line widths after reset, %0d output bytes checked",
                 items_sent, widths_used, bytes_checked);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: greedy_word_wrap_core.f
rtl/gww_pkg.sv
rtl/gww_word_ram.sv
rtl/greedy_word_wrap_core.sv
rtl/gww_checker.sv
tb/tb_greedy_word_wrap_core.sv
